FILE: src/jbx_pkg.sv
// Shared constants, types and helpers for the bytecode executor.
`timescale 1ns / 1ps

package jbx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_COUNT = 256;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int LA_W  = $clog2(LOCAL_COUNT);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SA_W-1:0]  saddr_t;
  typedef logic [LA_W-1:0]  laddr_t;
  typedef logic [31:0]      word_t;

  // Opcodes, standard numbering
  localparam logic [7:0] OP_ICONST_0     = 8'h03;
  localparam logic [7:0] OP_ICONST_1     = 8'h04;
  localparam logic [7:0] OP_ICONST_2     = 8'h05;
  localparam logic [7:0] OP_ICONST_3     = 8'h06;
  localparam logic [7:0] OP_ICONST_4     = 8'h07;
  localparam logic [7:0] OP_ICONST_5     = 8'h08;
  localparam logic [7:0] OP_BIPUSH       = 8'h10;
  localparam logic [7:0] OP_SIPUSH       = 8'h11;
  localparam logic [7:0] OP_ILOAD_0      = 8'h1A;
  localparam logic [7:0] OP_ILOAD_1      = 8'h1B;
  localparam logic [7:0] OP_ILOAD_2      = 8'h1C;
  localparam logic [7:0] OP_ISTORE_0     = 8'h3B;
  localparam logic [7:0] OP_ISTORE_1     = 8'h3C;
  localparam logic [7:0] OP_ISTORE_2     = 8'h3D;
  localparam logic [7:0] OP_IADD         = 8'h60;
  localparam logic [7:0] OP_IINC         = 8'h84;
  localparam logic [7:0] OP_IF_ICMPGT    = 8'hA3;
  localparam logic [7:0] OP_GOTO         = 8'hA7;
  localparam logic [7:0] OP_IRETURN      = 8'hAC;
  localparam logic [7:0] OP_RETURN       = 8'hB1;
  localparam logic [7:0] OP_GETSTATIC    = 8'hB2;
  localparam logic [7:0] OP_INVOKEVIRT   = 8'hB6;
  localparam logic [7:0] OP_LAST_NAMED   = 8'hCA;
  localparam logic [7:0] OP_FIRST_HIGH   = 8'hFE;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_BAD_LOCAL   = 3'd4
  } status_t;

  // What the execute stage does with the item
  typedef enum logic [3:0] {
    K_NONE,
    K_PUSH_IMM,
    K_PUSH_LOCAL,
    K_STORE,
    K_ADD,
    K_INC,
    K_CMPGT,
    K_PRINT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] pc_delta;
    logic [15:0] br_off;
    word_t       imm;
    logic        frame_end;
    saddr_t      stk_waddr;
    laddr_t      loc_addr;
  } issue_t;

  function automatic word_t sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  function automatic word_t sext16(input logic [7:0] hi, input logic [7:0] lo);
    sext16 = {{16{hi[7]}}, hi, lo};
  endfunction

endpackage

FILE: src/jbx_issue.sv
// Decode stage: stack count bookkeeping, error checks and memory read addresses.
`timescale 1ns / 1ps

module jbx_issue
  import jbx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] command,
  input  logic [7:0] operand_hi,
  input  logic [7:0] operand_lo,
  output issue_t     iss,
  output saddr_t     stk_raddr_top,
  output saddr_t     stk_raddr_nxt,
  output laddr_t     loc_raddr
);

  cnt_t count_r;
  cnt_t count_nxt;
  cnt_t cnt_m1;
  cnt_t cnt_m2;
  logic have1;
  logic have2;
  logic full;
  logic push;
  logic bad_local;

  assign cnt_m1    = count_r - cnt_t'(1);
  assign cnt_m2    = count_r - cnt_t'(2);
  assign have1     = (count_r != '0);
  assign have2     = (count_r >= cnt_t'(2));
  assign full      = (count_r >= cnt_t'(STACK_DEPTH));
  assign bad_local = ({1'b0, operand_hi} >= 9'(LOCAL_COUNT));

  assign stk_raddr_top = cnt_m1[SA_W-1:0];
  assign stk_raddr_nxt = cnt_m2[SA_W-1:0];

  // Pick the locals address: implicit index for iload, operand byte otherwise
  always_comb begin
    if (command == OP_ILOAD_0 || command == OP_ILOAD_1 || command == OP_ILOAD_2) begin
      loc_raddr = laddr_t'(command - OP_ILOAD_0);
    end else begin
      loc_raddr = operand_hi[LA_W-1:0];
    end
  end

  // Decode the item against the current stack count
  always_comb begin
    iss           = '0;
    iss.kind      = K_NONE;
    iss.status    = ST_OK;
    iss.br_off    = {operand_hi, operand_lo};
    iss.loc_addr  = loc_raddr;
    iss.stk_waddr = count_r[SA_W-1:0];
    count_nxt     = count_r;
    push          = 1'b0;
    unique case (command)
      OP_ICONST_0, OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4,
      OP_ICONST_5: begin
        push         = 1'b1;
        iss.kind     = K_PUSH_IMM;
        iss.imm      = word_t'(command - OP_ICONST_0);
        iss.pc_delta = 16'd1;
      end
      OP_BIPUSH: begin
        push         = 1'b1;
        iss.kind     = K_PUSH_IMM;
        iss.imm      = sext8(operand_hi);
        iss.pc_delta = 16'd2;
      end
      OP_SIPUSH: begin
        push         = 1'b1;
        iss.kind     = K_PUSH_IMM;
        iss.imm      = sext16(operand_hi, operand_lo);
        iss.pc_delta = 16'd3;
      end
      OP_GETSTATIC: begin
        push         = 1'b1;
        iss.kind     = K_PUSH_IMM;
        iss.pc_delta = 16'd3;
      end
      OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2: begin
        push         = 1'b1;
        iss.kind     = K_PUSH_LOCAL;
        iss.pc_delta = 16'd1;
      end
      OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2: begin
        if (!have1) begin
          iss.status = ST_UNDERFLOW;
        end else begin
          iss.kind     = K_STORE;
          iss.loc_addr = laddr_t'(command - OP_ISTORE_0);
          iss.pc_delta = 16'd1;
          count_nxt    = cnt_m1;
        end
      end
      OP_IADD: begin
        if (!have2) begin
          iss.status = ST_UNDERFLOW;
        end else begin
          iss.kind      = K_ADD;
          iss.stk_waddr = cnt_m2[SA_W-1:0];
          iss.pc_delta  = 16'd1;
          count_nxt     = cnt_m1;
        end
      end
      OP_IINC: begin
        if (bad_local) begin
          iss.status = ST_BAD_LOCAL;
        end else begin
          iss.kind     = K_INC;
          iss.imm      = sext8(operand_lo);
          iss.pc_delta = 16'd3;
        end
      end
      OP_IF_ICMPGT: begin
        if (!have2) begin
          iss.status = ST_UNDERFLOW;
        end else begin
          iss.kind  = K_CMPGT;
          count_nxt = cnt_m2;
        end
      end
      OP_GOTO: begin
        iss.pc_delta = {operand_hi, operand_lo};
      end
      OP_IRETURN: begin
        if (!have1) begin
          iss.status = ST_UNDERFLOW;
        end else begin
          iss.kind     = K_PRINT;
          iss.pc_delta = 16'd1;
          count_nxt    = cnt_m1;
        end
      end
      OP_RETURN: begin
        iss.frame_end = 1'b1;
        iss.pc_delta  = 16'd1;
      end
      OP_INVOKEVIRT: begin
        if (!have2) begin
          iss.status = ST_UNDERFLOW;
        end else begin
          iss.kind     = K_PRINT;
          iss.pc_delta = 16'd3;
          count_nxt    = cnt_m2;
        end
      end
      default: begin
        // undefined opcodes hold the pointer, named stubs step past
        iss.status   = ST_UNSUPPORTED;
        iss.pc_delta = (command <= OP_LAST_NAMED || command >= OP_FIRST_HIGH) ? 16'd1 : 16'd0;
      end
    endcase
    // Pushes need a free slot
    if (push) begin
      if (full) begin
        iss.status   = ST_OVERFLOW;
        iss.kind     = K_NONE;
        iss.pc_delta = 16'd0;
      end else begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
  end

  // Advance the stack count on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/jbx_stack_ram.sv
// Operand stack memory: two registered reads, one write, with write forwarding.
`timescale 1ns / 1ps

module jbx_stack_ram
  import jbx_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   rd_en,
  input  saddr_t rd_addr_a,
  input  saddr_t rd_addr_b,
  input  logic   wr_en,
  input  saddr_t wr_addr,
  input  word_t  wr_data,
  output word_t  rd_data_a,
  output word_t  rd_data_b
);

  word_t  mem [STACK_DEPTH];
  word_t  q_a_r;
  word_t  q_b_r;
  saddr_t raddr_a_r;
  saddr_t raddr_b_r;
  logic   fwd_en_r;
  saddr_t fwd_addr_r;
  word_t  fwd_data_r;

  // Read old data on a same-edge write; the forward register covers it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a_r     <= mem[rd_addr_a];
      q_b_r     <= mem[rd_addr_b];
      raddr_a_r <= rd_addr_a;
      raddr_b_r <= rd_addr_b;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      fwd_addr_r   <= wr_addr;
      fwd_data_r   <= wr_data;
    end
  end

  // Remember that a write has happened
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (wr_en) begin
      fwd_en_r <= 1'b1;
    end
  end

  // Bypass the latest write
  assign rd_data_a = (fwd_en_r && fwd_addr_r == raddr_a_r) ? fwd_data_r : q_a_r;
  assign rd_data_b = (fwd_en_r && fwd_addr_r == raddr_b_r) ? fwd_data_r : q_b_r;

endmodule

FILE: src/jbx_locals_ram.sv
// Local variable memory with per-entry valid bits and write forwarding.
`timescale 1ns / 1ps

module jbx_locals_ram
  import jbx_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   rd_en,
  input  laddr_t rd_addr,
  input  logic   wr_en,
  input  laddr_t wr_addr,
  input  word_t  wr_data,
  output word_t  rd_data
);

  word_t                  mem [LOCAL_COUNT];
  word_t                  q_r;
  laddr_t                 raddr_r;
  logic [LOCAL_COUNT-1:0] valid_r;
  logic                   fwd_en_r;
  laddr_t                 fwd_addr_r;
  word_t                  fwd_data_r;

  // Registered read, write with forward capture
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r     <= mem[rd_addr];
      raddr_r <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      fwd_addr_r   <= wr_addr;
      fwd_data_r   <= wr_data;
    end
  end

  // Valid bits: reset makes every local read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fwd_en_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      fwd_en_r         <= 1'b1;
    end
  end

  // Bypass the latest write, else mask entries never written
  always_comb begin
    if (fwd_en_r && fwd_addr_r == raddr_r) begin
      rd_data = fwd_data_r;
    end else if (valid_r[raddr_r]) begin
      rd_data = q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: src/java_bytecode_int_subset_executor.sv
// Top level: integer-subset bytecode executor, decode, memories and execute stage.
// Pipeline: decode and memory read are registered when an item is accepted, then
// execute writes the output register when the output side can take it.
// Throughput: one item per cycle while out_ready holds; the stack and locals
// memories each read in decode and write in execute, the last write forwarded.
// Reset (rst_n, synchronous): stack empty, all locals read as zero at once.
`timescale 1ns / 1ps

module java_bytecode_int_subset_executor
  import jbx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_command,
  input  logic [7:0]         in_operand_hi,
  input  logic [7:0]         in_operand_lo,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pc_delta,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic               out_frame_end,
  output logic [2:0]         out_status
);

  issue_t iss;
  issue_t b_ctrl_r;
  saddr_t stk_raddr_top;
  saddr_t stk_raddr_nxt;
  laddr_t loc_raddr;
  logic   accept;
  logic   b_valid_r;
  logic   b_valid_nxt;
  logic   b_adv;
  logic   b_fire;
  logic   out_valid_r;
  logic   out_valid_nxt;

  word_t  top_val;
  word_t  nxt_val;
  word_t  loc_val;
  logic   stk_we;
  word_t  stk_wdata;
  logic   loc_we;
  word_t  loc_wdata;
  logic [15:0] res_delta;
  logic        res_pvalid;
  word_t       res_pvalue;

  assign b_adv    = !out_valid_r || out_ready;
  assign in_ready = !b_valid_r || b_adv;
  assign accept   = in_valid && in_ready;
  assign b_fire   = b_valid_r && b_adv;

  jbx_issue u_issue (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .command       (in_command),
    .operand_hi    (in_operand_hi),
    .operand_lo    (in_operand_lo),
    .iss           (iss),
    .stk_raddr_top (stk_raddr_top),
    .stk_raddr_nxt (stk_raddr_nxt),
    .loc_raddr     (loc_raddr)
  );

  jbx_stack_ram u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (stk_raddr_top),
    .rd_addr_b (stk_raddr_nxt),
    .wr_en     (stk_we),
    .wr_addr   (b_ctrl_r.stk_waddr),
    .wr_data   (stk_wdata),
    .rd_data_a (top_val),
    .rd_data_b (nxt_val)
  );

  jbx_locals_ram u_locals (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (loc_raddr),
    .wr_en   (loc_we),
    .wr_addr (b_ctrl_r.loc_addr),
    .wr_data (loc_wdata),
    .rd_data (loc_val)
  );

  // Hold the decoded item alongside its memory reads
  always_ff @(posedge clk) begin
    if (accept) begin
      b_ctrl_r <= iss;
    end
  end

  // Execute: modify the read values, write back on advance
  always_comb begin
    stk_we     = 1'b0;
    stk_wdata  = b_ctrl_r.imm;
    loc_we     = 1'b0;
    loc_wdata  = top_val;
    res_delta  = b_ctrl_r.pc_delta;
    res_pvalid = 1'b0;
    res_pvalue = '0;
    unique case (b_ctrl_r.kind)
      K_PUSH_IMM: begin
        stk_we = b_fire;
      end
      K_PUSH_LOCAL: begin
        stk_we    = b_fire;
        stk_wdata = loc_val;
      end
      K_STORE: begin
        loc_we = b_fire;
      end
      K_ADD: begin
        stk_we    = b_fire;
        stk_wdata = nxt_val + top_val;
      end
      K_INC: begin
        loc_we    = b_fire;
        loc_wdata = loc_val + b_ctrl_r.imm;
      end
      K_CMPGT: begin
        res_delta = ($signed(nxt_val) > $signed(top_val)) ? b_ctrl_r.br_off : 16'd3;
      end
      K_PRINT: begin
        res_pvalid = 1'b1;
        res_pvalue = top_val;
      end
      K_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Pipeline occupancy
  always_comb begin
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end else begin
      b_valid_nxt = b_valid_r;
    end
    if (b_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_pc_delta    <= res_delta;
      out_print_valid <= res_pvalid;
      out_print_value <= res_pvalue;
      out_frame_end   <= b_ctrl_r.frame_end;
      out_status      <= b_ctrl_r.status;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted item always occupies the execute stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> b_valid_r)
    else $error("accepted item lost before execute");

  // A stalled execute stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> b_valid_r)
    else $error("execute item dropped while stalled");

  // Error results carry no print, no frame end and no advance
  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == ST_UNDERFLOW || out_status == ST_OVERFLOW ||
                     out_status == ST_BAD_LOCAL))
      |-> (!out_print_valid && !out_frame_end && out_pc_delta == 16'sd0))
    else $error("error result with side effects");

  // Memories are written only by an item leaving execute
  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_we || loc_we) |-> b_fire)
    else $error("memory write without an advancing item");

endmodule

FILE: tb/tb_java_bytecode_int_subset_executor.sv
// Self-checking testbench for the integer-subset bytecode executor.
`timescale 1ns / 1ps

module tb_java_bytecode_int_subset_executor
  import jbx_pkg::*;
();

  localparam int N_ITEMS     = 1250;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PRESS_AT    = 600;
  localparam int PRESS_LEN   = 300;

  typedef struct packed {
    logic [15:0] pc_delta;
    logic        print_valid;
    logic [31:0] print_value;
    logic        frame_end;
    logic [2:0]  status;
  } exec_result_t;

  // Track the stack machine state and check each result against its prediction
  class exec_checker;
    word_t        stk[STACK_DEPTH];
    int           depth;
    word_t        loc_mem[LOCAL_COUNT];
    exec_result_t pending_results[$];
    int           mismatches;
    int           n_checked;
    int           n_print;
    int           n_frame;
    int           n_over;
    int           n_under;
    int           n_unsup;

    function new();
      depth      = 0;
      mismatches = 0;
      n_checked  = 0;
      n_print    = 0;
      n_frame    = 0;
      n_over     = 0;
      n_under    = 0;
      n_unsup    = 0;
      foreach (loc_mem[i]) loc_mem[i] = '0;
      foreach (stk[i]) stk[i] = '0;
    endfunction

    // Execute one instruction against the tracked state
    function exec_result_t execute_op(logic [7:0] cmd, logic [7:0] hi, logic [7:0] lo);
      exec_result_t r;
      logic         do_push;
      word_t        pushed;
      word_t        v1;
      word_t        v2;
      r       = '0;
      r.status = ST_OK;
      do_push = 1'b0;
      pushed  = '0;
      case (cmd)
        OP_ICONST_0, OP_ICONST_1, OP_ICONST_2,
        OP_ICONST_3, OP_ICONST_4, OP_ICONST_5: begin
          do_push    = 1'b1;
          pushed     = 32'(cmd) - 32'(OP_ICONST_0);
          r.pc_delta = 16'd1;
        end
        OP_BIPUSH: begin
          do_push    = 1'b1;
          pushed     = {{24{hi[7]}}, hi};
          r.pc_delta = 16'd2;
        end
        OP_SIPUSH: begin
          do_push    = 1'b1;
          pushed     = {{16{hi[7]}}, hi, lo};
          r.pc_delta = 16'd3;
        end
        OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2: begin
          do_push    = 1'b1;
          pushed     = loc_mem[int'(cmd) - int'(OP_ILOAD_0)];
          r.pc_delta = 16'd1;
        end
        OP_GETSTATIC: begin
          do_push    = 1'b1;
          pushed     = '0;
          r.pc_delta = 16'd3;
        end
        OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2: begin
          if (depth < 1) begin
            r.status = ST_UNDERFLOW;
          end else begin
            depth--;
            loc_mem[int'(cmd) - int'(OP_ISTORE_0)] = stk[depth];
            r.pc_delta = 16'd1;
          end
        end
        OP_IADD: begin
          if (depth < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            stk[depth-2] = stk[depth-2] + stk[depth-1];
            depth--;
            r.pc_delta = 16'd1;
          end
        end
        OP_IINC: begin
          if (int'(hi) >= LOCAL_COUNT) begin
            r.status = ST_BAD_LOCAL;
          end else begin
            loc_mem[hi] = loc_mem[hi] + {{24{lo[7]}}, lo};
            r.pc_delta  = 16'd3;
          end
        end
        OP_IF_ICMPGT: begin
          if (depth < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            v2 = stk[depth-1];
            v1 = stk[depth-2];
            depth -= 2;
            r.pc_delta = ($signed(v1) > $signed(v2)) ? {hi, lo} : 16'd3;
          end
        end
        OP_GOTO: begin
          r.pc_delta = {hi, lo};
        end
        OP_IRETURN: begin
          if (depth < 1) begin
            r.status = ST_UNDERFLOW;
          end else begin
            depth--;
            r.print_value = stk[depth];
            r.print_valid = 1'b1;
            r.pc_delta    = 16'd1;
          end
        end
        OP_RETURN: begin
          r.frame_end = 1'b1;
          r.pc_delta  = 16'd1;
        end
        OP_INVOKEVIRT: begin
          if (depth < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            r.print_value = stk[depth-1];
            depth -= 2;
            r.print_valid = 1'b1;
            r.pc_delta    = 16'd3;
          end
        end
        default: begin
          r.status   = ST_UNSUPPORTED;
          r.pc_delta = (cmd <= OP_LAST_NAMED || cmd >= OP_FIRST_HIGH) ? 16'd1 : 16'd0;
        end
      endcase

      // Push onto the stack unless it is full
      if (do_push) begin
        if (depth >= STACK_DEPTH) begin
          r.status   = ST_OVERFLOW;
          r.pc_delta = 16'd0;
        end else begin
          stk[depth] = pushed;
          depth++;
        end
      end

      // Errors drop every side output
      if (r.status == ST_UNDERFLOW || r.status == ST_OVERFLOW || r.status == ST_BAD_LOCAL) begin
        r.pc_delta    = '0;
        r.print_valid = 1'b0;
        r.print_value = '0;
        r.frame_end   = 1'b0;
      end
      return r;
    endfunction

    function void note_item(logic [7:0] cmd, logic [7:0] hi, logic [7:0] lo);
      pending_results.push_back(execute_op(cmd, hi, lo));
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: pc_delta %0d status %0d", $realtime,
                   $signed(got.pc_delta), got.status);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (want.print_valid) n_print++;
      if (want.frame_end) n_frame++;
      if (want.status == ST_OVERFLOW) n_over++;
      if (want.status == ST_UNDERFLOW) n_under++;
      if (want.status == ST_UNSUPPORTED) n_unsup++;
      if (got.pc_delta !== want.pc_delta || got.print_valid !== want.print_valid ||
          got.print_value !== want.print_value || got.frame_end !== want.frame_end ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d mismatch", $realtime, n_checked);
          $display("  want pc_delta %0d pv %0b value %0d fe %0b status %0d",
                   $signed(want.pc_delta), want.print_valid, $signed(want.print_value),
                   want.frame_end, want.status);
          $display("  got  pc_delta %0d pv %0b value %0d fe %0b status %0d",
                   $signed(got.pc_delta), got.print_valid, $signed(got.print_value),
                   got.frame_end, got.status);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_command = '0;
  logic [7:0]         in_operand_hi = '0;
  logic [7:0]         in_operand_lo = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_pc_delta;
  logic               out_print_valid;
  logic signed [31:0] out_print_value;
  logic               out_frame_end;
  logic [2:0]         out_status;

  exec_checker sb = new();
  int          n_sent = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  int          push_bias = 50;

  java_bytecode_int_subset_executor i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_operand_hi   (in_operand_hi),
    .in_operand_lo   (in_operand_lo),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pc_delta    (out_pc_delta),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value),
    .out_frame_end   (out_frame_end),
    .out_status      (out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(logic [7:0] cmd, logic [7:0] hi, logic [7:0] lo);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_operand_hi <= hi;
    in_operand_lo <= lo;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, hi, lo);
    n_sent++;
  endtask

  // Pick a mostly well-formed instruction, biased toward pushes or pops
  task automatic send_random();
    logic [7:0] cmd;
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'($urandom);
    lo = 8'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      cmd = 8'($urandom);
    end else if ($urandom_range(0, 99) < push_bias) begin
      case ($urandom_range(0, 5))
        0:       cmd = OP_ICONST_0 + 8'($urandom_range(0, 5));
        1:       cmd = OP_BIPUSH;
        2:       cmd = OP_SIPUSH;
        3, 4:    cmd = OP_ILOAD_0 + 8'($urandom_range(0, 2));
        default: cmd = OP_GETSTATIC;
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    cmd = OP_ISTORE_0 + 8'($urandom_range(0, 2));
        2, 3:    cmd = OP_IADD;
        4:       cmd = OP_IINC;
        5:       cmd = OP_IF_ICMPGT;
        6:       cmd = OP_GOTO;
        7:       cmd = OP_IRETURN;
        8:       cmd = OP_RETURN;
        default: cmd = OP_INVOKEVIRT;
      endcase
    end
    if (cmd == OP_IINC && $urandom_range(0, 99) < 60) hi = 8'($urandom_range(0, 3));
    send_item(cmd, hi, lo);
  endtask

  // Drive the result side, with one long hold-off once the run is under way
  initial begin
    int  stall_left;
    int  hold_left;
    bit  pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && n_sent >= PRESS_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESS_LEN - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_pc_delta, out_print_valid, out_print_value,
                       out_frame_end, out_status});
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-stack errors and frame end first
    send_item(OP_IADD, 8'h00, 8'h00);
    send_item(OP_IRETURN, 8'h00, 8'h00);
    send_item(OP_ISTORE_0, 8'h00, 8'h00);
    send_item(OP_RETURN, 8'hFF, 8'hFF);
    for (int k = 0; k < 6; k++) send_item(OP_ICONST_0 + 8'(k), 8'h00, 8'h00);
    send_item(OP_BIPUSH, 8'h80, 8'h00);
    send_item(OP_BIPUSH, 8'h7F, 8'hFF);
    send_item(OP_SIPUSH, 8'h80, 8'h00);
    send_item(OP_SIPUSH, 8'h7F, 8'hFF);
    send_item(OP_IADD, 8'h00, 8'h00);
    send_item(OP_ISTORE_0, 8'h00, 8'h00);
    send_item(OP_IINC, 8'h00, 8'h80);
    send_item(OP_IINC, 8'hFF, 8'h7F);
    send_item(OP_ILOAD_0, 8'h00, 8'h00);
    send_item(OP_ILOAD_1, 8'h00, 8'h00);
    send_item(OP_ILOAD_2, 8'h00, 8'h00);
    send_item(OP_IF_ICMPGT, 8'h80, 8'h00);
    send_item(OP_GOTO, 8'hFF, 8'hFE);
    send_item(OP_GETSTATIC, 8'h00, 8'h00);
    send_item(OP_INVOKEVIRT, 8'h00, 8'h00);
    send_item(OP_IRETURN, 8'h00, 8'h00);
    // Unsupported: named, undefined and the two top codes
    send_item(8'h00, 8'h00, 8'h00);
    send_item(8'hCB, 8'h00, 8'h00);
    send_item(OP_FIRST_HIGH, 8'h00, 8'h00);
    send_item(8'hFF, 8'hFF, 8'hFF);

    // Random: phases that fill or drain the stack
    while (n_sent < N_ITEMS) begin
      if (n_sent % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 25;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
        calm = ($urandom_range(0, 4) == 0);
      end
      send_random();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d items, checked %0d results (%0d prints, %0d frame ends)",
             n_sent, sb.n_checked, sb.n_print, sb.n_frame);
    $display("Errors seen: %0d overflow, %0d underflow, %0d unsupported; %0d mismatches",
             sb.n_over, sb.n_under, sb.n_unsup, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/jbx_pkg.sv
src/jbx_issue.sv
src/jbx_stack_ram.sv
src/jbx_locals_ram.sv
src/java_bytecode_int_subset_executor.sv
tb/tb_java_bytecode_int_subset_executor.sv
